// ===== sv/frtg_pkg.sv =====
`timescale 1ns / 1ps
package frtg_pkg;

    // default width of the frequency and rate registers
    localparam int FREQ_BITS_DEF = 27;

    localparam int CYC_W    = 10;
    localparam int TICK_W   = 12;
    localparam int NUM_CHAN = 3;
    localparam int CHAN_W   = 2;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 4;

    // register reset values, truncated to the register width where used
    localparam logic [31:0] MASTER_FREQ_RST = 32'd7500000;
    localparam logic [31:0] COPROC_RATE_RST = 32'd11000000;
    localparam logic [31:0] BAUD_RATE_RST   = 32'd38400;
    localparam logic [31:0] DRIVE_RATE_RST  = 32'd100000;

    typedef enum logic [1:0] {
        REG_MASTER_FREQ = 2'd0,
        REG_COPROC_RATE = 2'd1,
        REG_BAUD_RATE   = 2'd2,
        REG_DRIVE_RATE  = 2'd3
    } reg_idx_t;

    typedef enum logic [CHAN_W-1:0] {
        CH_COPROC = 2'd0,
        CH_BAUD   = 2'd1,
        CH_DRIVE  = 2'd2
    } chan_t;

    typedef enum logic [1:0] {
        OP_IDLE = 2'd0,
        OP_MUL  = 2'd1,
        OP_ADD  = 2'd2,
        OP_DIV  = 2'd3
    } unit_op_t;

    typedef struct packed {
        unit_op_t op;
        chan_t    chan;
    } unit_ctl_t;

endpackage

// ===== sv/frtg_regs.sv =====
`timescale 1ns / 1ps
module frtg_regs #(
    parameter int FREQ_BITS = frtg_pkg::FREQ_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [frtg_pkg::APB_AW-1:0]   paddr,
    input  logic [frtg_pkg::APB_DW-1:0]   pwdata,
    output logic [frtg_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    output logic [FREQ_BITS-1:0]          master_freq,
    output logic [FREQ_BITS-1:0]          coproc_rate,
    output logic [FREQ_BITS-1:0]          baud_rate,
    output logic [FREQ_BITS-1:0]          drive_rate
);
    import frtg_pkg::*;

    logic [FREQ_BITS-1:0] master_freq_reg;
    logic [FREQ_BITS-1:0] coproc_rate_reg;
    logic [FREQ_BITS-1:0] baud_rate_reg;
    logic [FREQ_BITS-1:0] drive_rate_reg;
    reg_idx_t             idx;
    logic                 wr_en;

    assign idx    = reg_idx_t'(paddr[APB_AW-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            master_freq_reg <= MASTER_FREQ_RST[FREQ_BITS-1:0];
            coproc_rate_reg <= COPROC_RATE_RST[FREQ_BITS-1:0];
            baud_rate_reg   <= BAUD_RATE_RST[FREQ_BITS-1:0];
            drive_rate_reg  <= DRIVE_RATE_RST[FREQ_BITS-1:0];
        end else if (wr_en) begin
            case (idx)
                REG_MASTER_FREQ: master_freq_reg <= pwdata[FREQ_BITS-1:0];
                REG_COPROC_RATE: coproc_rate_reg <= pwdata[FREQ_BITS-1:0];
                REG_BAUD_RATE:   baud_rate_reg   <= pwdata[FREQ_BITS-1:0];
                REG_DRIVE_RATE:  drive_rate_reg  <= pwdata[FREQ_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_MASTER_FREQ: prdata = APB_DW'(master_freq_reg);
            REG_COPROC_RATE: prdata = APB_DW'(coproc_rate_reg);
            REG_BAUD_RATE:   prdata = APB_DW'(baud_rate_reg);
            REG_DRIVE_RATE:  prdata = APB_DW'(drive_rate_reg);
            default:         prdata = '0;
        endcase
    end

    assign master_freq = master_freq_reg;
    assign coproc_rate = coproc_rate_reg;
    assign baud_rate   = baud_rate_reg;
    assign drive_rate  = drive_rate_reg;

endmodule

// ===== sv/frtg_unit.sv =====
`timescale 1ns / 1ps
module frtg_unit #(
    parameter int FREQ_BITS = frtg_pkg::FREQ_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  frtg_pkg::unit_ctl_t           ctl,
    input  logic [frtg_pkg::CYC_W-1:0]    cycles,
    input  logic [FREQ_BITS-1:0]          master_freq,
    input  logic [FREQ_BITS-1:0]          coproc_rate,
    input  logic [FREQ_BITS-1:0]          baud_rate,
    input  logic [FREQ_BITS-1:0]          drive_rate,
    input  logic [FREQ_BITS-1:0]          phase,
    output logic [FREQ_BITS-1:0]          rem,
    output logic [frtg_pkg::TICK_W-1:0]   ticks
);
    import frtg_pkg::*;

    localparam int PW = FREQ_BITS + CYC_W;
    localparam int AW = PW + 1;

    logic [FREQ_BITS-1:0] rate_sel;
    logic [PW-1:0]        prod_reg;
    logic [AW-1:0]        acc_reg;
    logic [FREQ_BITS-1:0] rem_reg;
    logic [TICK_W-1:0]    quot_reg;
    logic                 sat_reg;
    logic [FREQ_BITS:0]   partial;
    logic [FREQ_BITS:0]   divisor;
    logic                 ge;
    logic [FREQ_BITS:0]   diff;

    always_comb begin
        case (ctl.chan)
            CH_COPROC: rate_sel = coproc_rate;
            CH_BAUD:   rate_sel = baud_rate;
            CH_DRIVE:  rate_sel = drive_rate;
            default:   rate_sel = '0;
        endcase
    end

    // one restoring division step: shift in the next dividend bit
    assign partial = {rem_reg, acc_reg[AW-1]};
    assign divisor = {1'b0, master_freq};
    assign ge      = partial >= divisor;
    assign diff    = partial - divisor;

    always_ff @(posedge aclk) begin
        case (ctl.op)
            OP_MUL: prod_reg <= PW'(cycles) * PW'(rate_sel);
            OP_ADD: begin
                acc_reg  <= AW'(prod_reg) + AW'(phase);
                rem_reg  <= '0;
                quot_reg <= '0;
                sat_reg  <= 1'b0;
            end
            OP_DIV: begin
                acc_reg  <= {acc_reg[AW-2:0], 1'b0};
                rem_reg  <= ge ? diff[FREQ_BITS-1:0] : partial[FREQ_BITS-1:0];
                quot_reg <= {quot_reg[TICK_W-2:0], ge};
                sat_reg  <= sat_reg | quot_reg[TICK_W-1];
            end
            default: ;
        endcase
    end

    assign rem   = rem_reg;
    assign ticks = sat_reg ? '1 : quot_reg;

    // partial remainder stays below the divisor after every step
    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctl.op == OP_DIV && master_freq != '0) |=> rem_reg < $past(master_freq))
        else $error("remainder not below master frequency");

endmodule

// ===== sv/frtg_seq.sv =====
`timescale 1ns / 1ps
module frtg_seq #(
    parameter int FREQ_BITS = frtg_pkg::FREQ_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [frtg_pkg::CYC_W-1:0]    s_elapsed_cycles,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [frtg_pkg::TICK_W-1:0]   m_coproc_ticks,
    output logic [frtg_pkg::TICK_W-1:0]   m_baud_ticks,
    output logic [frtg_pkg::TICK_W-1:0]   m_drive_ticks,
    input  logic [FREQ_BITS-1:0]          master_freq,
    output frtg_pkg::unit_ctl_t           ctl,
    output logic [frtg_pkg::CYC_W-1:0]    cycles,
    output logic [FREQ_BITS-1:0]          phase,
    input  logic [FREQ_BITS-1:0]          rem,
    input  logic [frtg_pkg::TICK_W-1:0]   ticks
);
    import frtg_pkg::*;

    localparam int AW    = FREQ_BITS + CYC_W + 1;
    localparam int CNT_W = $clog2(AW);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ADD,
        S_DIV,
        S_STORE,
        S_OUT
    } state_t;

    state_t               state_reg;
    chan_t                chan_reg;
    logic [CNT_W-1:0]     div_cnt_reg;
    logic [CYC_W-1:0]     cycles_reg;
    logic [FREQ_BITS-1:0] phase_reg [NUM_CHAN];
    logic [TICK_W-1:0]    tick_reg  [NUM_CHAN];
    logic                 m_valid_reg;
    logic [TICK_W-1:0]    m_coproc_reg;
    logic [TICK_W-1:0]    m_baud_reg;
    logic [TICK_W-1:0]    m_drive_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            chan_reg    <= CH_COPROC;
            div_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_CHAN; i++) begin
                phase_reg[i] <= '0;
            end
        end else begin
            // output state reloads the result register itself
            if (m_valid_reg && m_ready && state_reg != S_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        cycles_reg <= s_elapsed_cycles;
                        chan_reg   <= CH_COPROC;
                        state_reg  <= S_MUL;
                    end
                end
                S_MUL: state_reg <= S_ADD;
                S_ADD: begin
                    div_cnt_reg <= '0;
                    state_reg   <= S_DIV;
                end
                S_DIV: begin
                    div_cnt_reg <= div_cnt_reg + 1'b1;
                    if (div_cnt_reg == CNT_W'(AW - 1)) begin
                        state_reg <= S_STORE;
                    end
                end
                S_STORE: begin
                    // zero master frequency: no ticks, phase holds
                    if (master_freq != '0) begin
                        phase_reg[chan_reg] <= rem;
                        tick_reg[chan_reg]  <= ticks;
                    end else begin
                        tick_reg[chan_reg]  <= '0;
                    end
                    if (chan_reg == CH_DRIVE) begin
                        state_reg <= S_OUT;
                    end else begin
                        chan_reg  <= chan_t'(chan_reg + 1'b1);
                        state_reg <= S_MUL;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_coproc_reg <= tick_reg[CH_COPROC];
                        m_baud_reg   <= tick_reg[CH_BAUD];
                        m_drive_reg  <= tick_reg[CH_DRIVE];
                        m_valid_reg  <= 1'b1;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        ctl.chan = chan_reg;
        case (state_reg)
            S_MUL:   ctl.op = OP_MUL;
            S_ADD:   ctl.op = OP_ADD;
            S_DIV:   ctl.op = OP_DIV;
            default: ctl.op = OP_IDLE;
        endcase
    end

    assign cycles         = cycles_reg;
    assign phase          = phase_reg[chan_reg];
    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_coproc_ticks = m_coproc_reg;
    assign m_baud_ticks   = m_baud_reg;
    assign m_drive_ticks  = m_drive_reg;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted while previous one still in work");

    a_div_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DIV) |-> (div_cnt_reg <= CNT_W'(AW - 1)))
        else $error("division step counter out of range");

    a_result_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result raised outside output state");

    a_chan_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> (chan_reg != chan_t'(NUM_CHAN)))
        else $error("channel index beyond last channel");

endmodule

// ===== sv/fractional_rate_tick_generator.sv =====
`timescale 1ns / 1ps
// fractional-rate tick generator
// three tick channels (coprocessor, baud x4, drive bit) derived from one
// master clock by phase accumulators with exact remainders
// input request: s_elapsed_cycles, master cycles since the previous request
// result request: per-channel tick counts, saturated at 4095
// per channel: phase + cycles * rate, divided by master_freq; quotient is the
// tick count, remainder is the new phase
// one shared multiplier / restoring divider is stepped by a small sequencer,
// channel by channel, one quotient bit per cycle
// s_ready is high only between requests; one request is in work at a time
// the result sits in an output register, so the next request is taken while
// an earlier result still waits on m_ready; a stalled receiver holds the
// block only when a second result is ready to be written
// reset clears the phases and loads the default register values
// registers over APB: master_freq 0x0, coproc_rate 0x4, baud_rate 0x8,
// drive_rate 0xc; write them only while no request is in work
module fractional_rate_tick_generator #(
    parameter int FREQ_BITS = frtg_pkg::FREQ_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // input requests
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [frtg_pkg::CYC_W-1:0]    s_elapsed_cycles,
    // result requests
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [frtg_pkg::TICK_W-1:0]   m_coproc_ticks,
    output logic [frtg_pkg::TICK_W-1:0]   m_baud_ticks,
    output logic [frtg_pkg::TICK_W-1:0]   m_drive_ticks,
    // register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [frtg_pkg::APB_AW-1:0]   paddr,
    input  logic [frtg_pkg::APB_DW-1:0]   pwdata,
    output logic [frtg_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import frtg_pkg::*;

    // register values
    logic [FREQ_BITS-1:0] master_freq;
    logic [FREQ_BITS-1:0] coproc_rate;
    logic [FREQ_BITS-1:0] baud_rate;
    logic [FREQ_BITS-1:0] drive_rate;

    // sequencer to shared unit
    unit_ctl_t            ctl;
    logic [CYC_W-1:0]     cycles;
    logic [FREQ_BITS-1:0] phase;

    // shared unit back to sequencer
    logic [FREQ_BITS-1:0] rem;
    logic [TICK_W-1:0]    ticks;

    frtg_regs #(
        .FREQ_BITS (FREQ_BITS)
    ) u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .master_freq (master_freq),
        .coproc_rate (coproc_rate),
        .baud_rate   (baud_rate),
        .drive_rate  (drive_rate)
    );

    // sequencer: channel loop, divide step count, phases, output register
    frtg_seq #(
        .FREQ_BITS (FREQ_BITS)
    ) u_seq (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_elapsed_cycles (s_elapsed_cycles),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_coproc_ticks   (m_coproc_ticks),
        .m_baud_ticks     (m_baud_ticks),
        .m_drive_ticks    (m_drive_ticks),
        .master_freq      (master_freq),
        .ctl              (ctl),
        .cycles           (cycles),
        .phase            (phase),
        .rem              (rem),
        .ticks            (ticks)
    );

    // shared arithmetic: multiply, accumulate, one division bit per step
    frtg_unit #(
        .FREQ_BITS (FREQ_BITS)
    ) u_unit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctl         (ctl),
        .cycles      (cycles),
        .master_freq (master_freq),
        .coproc_rate (coproc_rate),
        .baud_rate   (baud_rate),
        .drive_rate  (drive_rate),
        .phase       (phase),
        .rem         (rem),
        .ticks       (ticks)
    );

endmodule
